[hw/rtl/bipt_pkg.sv]
// ----------------------------------------------------------------------------
// bipt_pkg: shared types, constants and helpers
// Sizes, weight-memory request type and saturation helpers of the trainer.
// ----------------------------------------------------------------------------
package bipt_pkg;

    localparam int N_INPUTS    = 30;
    localparam int WEIGHT_BITS = 16;
    localparam int SUM_BITS    = 21;
    localparam int N_WEIGHTS   = N_INPUTS + 1;
    localparam int ADDR_W      = $clog2(N_WEIGHTS);
    localparam int ACC_BITS    = WEIGHT_BITS + $clog2(N_WEIGHTS);
    localparam int CLIP_BITS   = ACC_BITS + SUM_BITS;

    typedef logic [ADDR_W-1:0]             addr_t;
    typedef logic signed [WEIGHT_BITS-1:0] weight_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;

    // One cycle's worth of weight-memory traffic
    typedef struct packed {
        logic    re;
        addr_t   raddr;
        logic    we;
        addr_t   waddr;
        weight_t wdata;
    } ram_req_t;

    localparam logic signed [WEIGHT_BITS:0] W_MAX_X =
        (WEIGHT_BITS+1)'((64'd1 << (WEIGHT_BITS - 1)) - 64'd1);
    localparam logic signed [WEIGHT_BITS:0] W_MIN_X = -W_MAX_X - (WEIGHT_BITS+1)'(1);

    localparam logic signed [CLIP_BITS-1:0] S_MAX_X =
        CLIP_BITS'((64'd1 << (SUM_BITS - 1)) - 64'd1);
    localparam logic signed [CLIP_BITS-1:0] S_MIN_X = -S_MAX_X - CLIP_BITS'(1);

    // Step a weight by +1 or -1, holding it at its signed limits
    function automatic weight_t step_weight(input weight_t w, input logic up);
        logic signed [WEIGHT_BITS:0] v;
        v = up ? ((WEIGHT_BITS+1)'(w) + (WEIGHT_BITS+1)'(1))
               : ((WEIGHT_BITS+1)'(w) - (WEIGHT_BITS+1)'(1));
        if (v > W_MAX_X)
        begin
            v = W_MAX_X;
        end
        else if (v < W_MIN_X)
        begin
            v = W_MIN_X;
        end
        return v[WEIGHT_BITS-1:0];
    endfunction

    // Saturate the accumulator into the reported sum range
    function automatic sum_t clip_sum(input acc_t a);
        logic signed [CLIP_BITS-1:0] v;
        v = CLIP_BITS'(a);
        if (v > S_MAX_X)
        begin
            v = S_MAX_X;
        end
        else if (v < S_MIN_X)
        begin
            v = S_MIN_X;
        end
        return v[SUM_BITS-1:0];
    endfunction

endpackage

[hw/rtl/bipt_if.sv]
// ----------------------------------------------------------------------------
// bipt_if: channel interfaces
// Valid/ready channels for incoming patterns and outgoing classifications.
// ----------------------------------------------------------------------------
interface bipt_in_if;
    import bipt_pkg::*;

    logic                valid;
    logic                ready;
    logic                action;
    logic [N_INPUTS-1:0] pixels;
    logic                target;

    modport source (output valid, action, pixels, target, input ready);
    modport sink   (input valid, action, pixels, target, output ready);
endinterface

interface bipt_out_if;
    import bipt_pkg::*;

    logic       valid;
    logic       ready;
    logic       answer;
    sum_t       weighted_sum;
    logic       corrected;

    modport source (output valid, answer, weighted_sum, corrected, input ready);
    modport sink   (input valid, answer, weighted_sum, corrected, output ready);
endinterface

[hw/rtl/bipt_weight_ram.sv]
// ----------------------------------------------------------------------------
// bipt_weight_ram: weight store
// One write and one registered read per cycle; entries read zero until
// first written after reset.
// ----------------------------------------------------------------------------
module bipt_weight_ram (
    input  logic               clk,
    input  logic               rst_n,
    input  bipt_pkg::ram_req_t req,
    output bipt_pkg::weight_t  rd_data
);
    import bipt_pkg::*;

    weight_t              mem [N_WEIGHTS];
    logic [N_WEIGHTS-1:0] valid_reg;
    logic [N_WEIGHTS-1:0] valid_next;
    weight_t              rd_data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.we)
        begin
            valid_next[req.waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= valid_reg[req.raddr] ? mem[req.raddr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

`ifndef SYNTHESIS
    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        req.we |-> (int'(req.waddr) < N_WEIGHTS))
        else $error("weight write beyond store");
    a_raddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        req.re |-> (int'(req.raddr) < N_WEIGHTS))
        else $error("weight read beyond store");
    a_valid_grows: assert property (@(posedge clk) disable iff (!rst_n)
        req.we |=> valid_reg[$past(req.waddr)])
        else $error("written entry not marked valid");
`endif

endmodule

[hw/rtl/bipt_ctrl.sv]
// ----------------------------------------------------------------------------
// bipt_ctrl: sum and update sequencer
// Sweeps the weight store once to form the sum, sweeps it again with
// read-modify-write when the learning rule fires, and holds the result.
// ----------------------------------------------------------------------------
module bipt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    bipt_in_if.sink            sample,
    bipt_out_if.source         result,
    output bipt_pkg::ram_req_t ram_req,
    input  bipt_pkg::weight_t  rd_data
);
    import bipt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SUM    = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_UPD    = 3'd4;
    localparam logic [2:0] S_UDRAIN = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    localparam addr_t LAST = ADDR_W'(N_WEIGHTS - 1);

    logic [2:0]           state_reg, state_next;
    addr_t                cnt_reg, cnt_next;
    logic                 sum_pend_reg, sum_pend_next;
    logic                 upd_pend_reg, upd_pend_next;
    addr_t                pidx_reg;
    logic                 out_valid_reg, out_valid_next;

    logic [N_WEIGHTS-1:0] sel_reg;
    logic                 act_reg;
    logic                 tgt_reg;
    acc_t                 acc_reg, acc_next;
    logic                 up_reg;
    logic                 ans_reg;
    logic                 corr_reg;
    logic                 out_answer_reg;
    sum_t                 out_sum_reg;
    logic                 out_corr_reg;

    logic accept;
    logic issue;
    logic ans_now;
    logic fire;
    logic load_out;

    assign accept   = sample.valid && sample.ready;
    assign issue    = (state_reg == S_SUM) || (state_reg == S_UPD);
    assign ans_now  = (acc_reg > acc_t'(0));
    assign fire     = act_reg && (ans_now != tgt_reg);
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    // Memory traffic: read the entry under the counter, write back the one
    // read in the previous cycle; the two never coincide.
    always_comb
    begin
        ram_req.re    = issue;
        ram_req.raddr = cnt_reg;
        ram_req.we    = upd_pend_reg && sel_reg[pidx_reg];
        ram_req.waddr = pidx_reg;
        ram_req.wdata = step_weight(rd_data, up_reg);
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (accept)
        begin
            acc_next = '0;
        end
        else if (sum_pend_reg && sel_reg[pidx_reg])
        begin
            acc_next = acc_reg + ACC_BITS'(rd_data);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sum_pend_next  = (state_reg == S_SUM);
        upd_pend_next  = (state_reg == S_UPD);
        out_valid_next = out_valid_reg;
        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = '0;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cnt_next = cnt_reg + ADDR_W'(1);
                if (cnt_reg == LAST)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cnt_next   = '0;
                state_next = fire ? S_UPD : S_DONE;
            end
            S_UPD:
            begin
                cnt_next = cnt_reg + ADDR_W'(1);
                if (cnt_reg == LAST)
                begin
                    state_next = S_UDRAIN;
                end
            end
            S_UDRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            sum_pend_reg  <= 1'b0;
            upd_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sum_pend_reg  <= sum_pend_next;
            upd_pend_reg  <= upd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (issue)
        begin
            pidx_reg <= cnt_reg;
        end
        if (accept)
        begin
            sel_reg <= {sample.pixels, 1'b1};
            act_reg <= sample.action;
            tgt_reg <= sample.target;
        end
        if (state_reg == S_DECIDE)
        begin
            ans_reg  <= ans_now;
            corr_reg <= fire;
            up_reg   <= !ans_now;
        end
        if (load_out)
        begin
            out_answer_reg <= ans_reg;
            out_sum_reg    <= clip_sum(acc_reg);
            out_corr_reg   <= corr_reg;
        end
    end

    assign sample.ready        = (state_reg == S_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.answer       = out_answer_reg;
    assign result.weighted_sum = out_sum_reg;
    assign result.corrected    = out_corr_reg;

`ifndef SYNTHESIS
    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
        else $error("read and write-back hit the same weight");
    a_write_only_upd: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> ((state_reg == S_UPD) || (state_reg == S_UDRAIN)))
        else $error("weight written outside update sweep");
    a_upd_needs_train: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && state_next == S_UPD) |-> act_reg)
        else $error("update sweep started for classify-only item");
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done state");
`endif

endmodule

[hw/rtl/binary_input_perceptron_trainer.sv]
// ----------------------------------------------------------------------------
// binary_input_perceptron_trainer: single-neuron perceptron with learning rule
// Classifies 30-pixel binary patterns against stored weights and, in train
// mode, nudges the bias and the set pixels' weights toward the target.
// ----------------------------------------------------------------------------
//
//   channel   role   payload
//   -------   ----   ------------------------------------------------
//   sample    sink   action, pixels[29:0], target
//   result    source answer, weighted_sum[20:0] (signed), corrected
//
// One transaction in gives exactly one transaction out.
// Work: a classify, or a train item that needs no correction, runs one sum
// sweep between acceptance and the result register; a corrected train
// item adds an update sweep. Both sweep the 31-entry weight
// memory: one read per cycle for the sum, then one read-modify-write per
// cycle for the update.
// Reset clears the weight store to zero at once through per-entry valid
// bits; no clearing pass is needed.
// A stalled result stays in the output register; the next sample
// transaction is taken meanwhile and waits at the end of its work.
// ----------------------------------------------------------------------------
module binary_input_perceptron_trainer (
    input  logic       clk,
    input  logic       rst_n,
    bipt_in_if.sink    sample,
    bipt_out_if.source result
);
    import bipt_pkg::*;

    ram_req_t ram_req;
    weight_t  rd_data;

    // Sequencer: sum sweep, decision, optional update sweep, result hold
    bipt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample),
        .result  (result),
        .ram_req (ram_req),
        .rd_data (rd_data)
    );

    // Weight store: entry 0 is the bias, entry i+1 belongs to pixel i
    bipt_weight_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (rd_data)
    );

endmodule

[bench/tb_binary_input_perceptron_trainer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_input_perceptron_trainer: self-checking bench for the trainer
// Drives binary patterns in classify and train mode, keeps a shadow copy of
// the 31 weights, and compares every classification field by field.
// ----------------------------------------------------------------------------
module tb_binary_input_perceptron_trainer;
    import bipt_pkg::*;

    // Saturation limits of a weight and of the reported sum
    localparam longint WEIGHT_TOP = (longint'(1) << (WEIGHT_BITS - 1)) - 1;
    localparam longint WEIGHT_BOT = -WEIGHT_TOP - 1;
    localparam longint SUM_TOP    = (longint'(1) << (SUM_BITS - 1)) - 1;
    localparam longint SUM_BOT    = -SUM_TOP - 1;

    // Slowest item is a corrected train, which runs both weight sweeps
    localparam int SETTLE_CYCLES = 100;

    localparam logic ACT_CLASSIFY = 1'b0;
    localparam logic ACT_TRAIN    = 1'b1;

    localparam logic [N_INPUTS-1:0] NO_PIXELS  = '0;
    localparam logic [N_INPUTS-1:0] ALL_PIXELS = '1;
    localparam logic [N_INPUTS-1:0] EVEN_PIXELS = {(N_INPUTS / 2){2'b01}};
    localparam logic [N_INPUTS-1:0] ODD_PIXELS  = {(N_INPUTS / 2){2'b10}};

    // One classification as the result channel carries it
    typedef struct {
        logic answer;
        sum_t weighted_sum;
        logic corrected;
    } outcome_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bipt_in_if  sample_ch ();
    bipt_out_if result_ch ();

    // Shadow of the weight store: entry 0 is the bias, entry i+1 is pixel i
    weight_t  shadow_weights [N_WEIGHTS];
    outcome_t expected_outcomes [$];

    int unsigned source_gap_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned patterns_sent    = 0;
    int unsigned outcomes_checked = 0;
    int unsigned corrections_seen = 0;
    int unsigned error_count      = 0;

    binary_input_perceptron_trainer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Apply one step of the perceptron rule to the shadow weights and
    // queue the classification the block must report for it
    function automatic void predict_step(input logic act, input logic [N_INPUTS-1:0] pix,
                                         input logic tgt);
        logic [N_WEIGHTS-1:0] members;
        longint               total;
        longint               stepped;
        longint               delta;
        outcome_t             outcome;
        members = {pix, 1'b1};
        total   = 0;
        for (int k = 0; k < N_WEIGHTS; k++)
        begin
            if (members[k])
            begin
                total += longint'(shadow_weights[k]);
            end
        end
        outcome.answer    = (total > 0);
        outcome.corrected = (act == ACT_TRAIN) && (outcome.answer != tgt);
        if (outcome.corrected)
        begin
            // Push toward the target: up when the answer fell short, down otherwise
            delta = outcome.answer ? -1 : 1;
            for (int k = 0; k < N_WEIGHTS; k++)
            begin
                if (members[k])
                begin
                    stepped = longint'(shadow_weights[k]) + delta;
                    if (stepped > WEIGHT_TOP)
                    begin
                        stepped = WEIGHT_TOP;
                    end
                    else if (stepped < WEIGHT_BOT)
                    begin
                        stepped = WEIGHT_BOT;
                    end
                    shadow_weights[k] = weight_t'(stepped);
                end
            end
        end
        if (total > SUM_TOP)
        begin
            total = SUM_TOP;
        end
        else if (total < SUM_BOT)
        begin
            total = SUM_BOT;
        end
        outcome.weighted_sum = sum_t'(total);
        expected_outcomes.push_back(outcome);
    endfunction

    // Pick a pattern from a spread of densities so every pixel sees both values
    function automatic logic [N_INPUTS-1:0] pick_pixels();
        case ($urandom_range(5))
            0: return N_INPUTS'($urandom());
            1: return N_INPUTS'($urandom() & $urandom() & $urandom());
            2: return N_INPUTS'($urandom() | $urandom() | $urandom());
            3: return N_INPUTS'(1) << $urandom_range(N_INPUTS - 1);
            4: return ~(N_INPUTS'(1) << $urandom_range(N_INPUTS - 1));
            default: return $urandom_range(1) ? ALL_PIXELS : NO_PIXELS;
        endcase
    endfunction

    // Send one pattern; called and left at a falling edge, valid stays high
    // after acceptance so back-to-back transactions need no extra assignment
    task automatic send_pattern(input logic act, input logic [N_INPUTS-1:0] pix,
                                input logic tgt);
        if ($urandom_range(99) < source_gap_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < source_gap_pct)
            begin
                @(negedge clk);
            end
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.action <= act;
        sample_ch.pixels <= pix;
        sample_ch.target <= tgt;
        @(posedge clk);
        while (!sample_ch.ready)
        begin
            @(posedge clk);
        end
        predict_step(act, pix, tgt);
        patterns_sent++;
        @(negedge clk);
    endtask

    // Drop valid and hold off until every queued classification is back
    task automatic hold_until_drained();
        sample_ch.valid <= 1'b0;
        @(negedge clk);
        while (expected_outcomes.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Fresh weights are all zero: every sum is zero and every answer is 0
    task automatic test_fresh_weights();
        send_pattern(ACT_CLASSIFY, NO_PIXELS, 1'b1);
        send_pattern(ACT_CLASSIFY, ALL_PIXELS, 1'b0);
        send_pattern(ACT_CLASSIFY, EVEN_PIXELS, 1'b1);
        send_pattern(ACT_CLASSIFY, ODD_PIXELS, 1'b0);
        // Target already met: no correction
        send_pattern(ACT_TRAIN, ALL_PIXELS, 1'b0);
    endtask

    // Walk the rule through both directions, the ignored target in classify
    // mode, and the bias-only and single-pixel corners
    task automatic test_learning_rule();
        send_pattern(ACT_TRAIN, ALL_PIXELS, 1'b1);
        send_pattern(ACT_CLASSIFY, ALL_PIXELS, 1'b0);
        send_pattern(ACT_TRAIN, ALL_PIXELS, 1'b1);
        send_pattern(ACT_TRAIN, N_INPUTS'(1) << (N_INPUTS - 1), 1'b0);
        send_pattern(ACT_CLASSIFY, N_INPUTS'(1) << (N_INPUTS - 1), 1'b1);
        send_pattern(ACT_CLASSIFY, N_INPUTS'(1), 1'b1);
        send_pattern(ACT_TRAIN, NO_PIXELS, 1'b1);
        send_pattern(ACT_TRAIN, NO_PIXELS, 1'b0);
        send_pattern(ACT_TRAIN, NO_PIXELS, 1'b0);
        send_pattern(ACT_TRAIN, ODD_PIXELS, 1'b0);
        send_pattern(ACT_TRAIN, ODD_PIXELS, 1'b0);
        send_pattern(ACT_CLASSIFY, EVEN_PIXELS, 1'b0);
        send_pattern(ACT_TRAIN, EVEN_PIXELS, 1'b1);
        send_pattern(ACT_TRAIN, EVEN_PIXELS, 1'b0);
        send_pattern(ACT_CLASSIFY, ODD_PIXELS, 1'b1);
        send_pattern(ACT_TRAIN, ALL_PIXELS, 1'b0);
        send_pattern(ACT_CLASSIFY, ALL_PIXELS, 1'b1);
    endtask

    // Train on a small labeled set, as a real epoch loop would, with some
    // stray patterns and classify-only probes mixed in
    task automatic test_training_set(input int unsigned count, input int unsigned pool_size);
        logic [N_INPUTS-1:0] pool_pixels [$];
        logic                pool_labels [$];
        int unsigned         pick;
        for (int unsigned p = 0; p < pool_size; p++)
        begin
            pool_pixels.push_back(pick_pixels());
            pool_labels.push_back(1'($urandom_range(1)));
        end
        for (int unsigned n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_pattern(1'($urandom_range(1)), pick_pixels(), 1'($urandom_range(1)));
            end
            else
            begin
                pick = $urandom_range(pool_size - 1);
                send_pattern(($urandom_range(99) < 80) ? ACT_TRAIN : ACT_CLASSIFY,
                             pool_pixels[pick], pool_labels[pick]);
            end
        end
    endtask

    // Unrelated random patterns; halfway through, stop feeding until the
    // block has returned every classification
    task automatic test_random_patterns(input int unsigned count);
        for (int unsigned n = 0; n < count; n++)
        begin
            if (n == count / 2)
            begin
                hold_until_drained();
            end
            send_pattern(1'($urandom_range(1)), pick_pixels(), 1'($urandom_range(1)));
        end
    endtask

    // Receiver: stall at the configured rate, new decision every falling edge
    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Check each result transaction against the oldest expectation
    always @(posedge clk)
    begin : check_outcomes
        outcome_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $error("result with no classification pending: answer %0d sum %0d",
                       result_ch.answer, result_ch.weighted_sum);
                error_count++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                outcomes_checked++;
                if (result_ch.corrected === 1'b1)
                begin
                    corrections_seen++;
                end
                if (result_ch.answer !== want.answer)
                begin
                    $error("answer: expected %0d, actual %0d", want.answer, result_ch.answer);
                    error_count++;
                end
                if (result_ch.weighted_sum !== want.weighted_sum)
                begin
                    $error("weighted_sum: expected %0d, actual %0d",
                           want.weighted_sum, result_ch.weighted_sum);
                    error_count++;
                end
                if (result_ch.corrected !== want.corrected)
                begin
                    $error("corrected: expected %0d, actual %0d",
                           want.corrected, result_ch.corrected);
                    error_count++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        // Hold every input at a known value through reset
        sample_ch.valid  = 1'b0;
        sample_ch.action = ACT_CLASSIFY;
        sample_ch.pixels = NO_PIXELS;
        sample_ch.target = 1'b0;
        result_ch.ready  = 1'b0;
        for (int k = 0; k < N_WEIGHTS; k++)
        begin
            shadow_weights[k] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed checks run without idling
        test_fresh_weights();
        test_learning_rule();

        // Eager sender, sluggish receiver
        source_gap_pct = 9;
        sink_stall_pct = 83;
        test_training_set(350, 6);

        // Sluggish sender, eager receiver
        source_gap_pct = 83;
        sink_stall_pct = 9;
        test_random_patterns(350);

        // Full rate on both sides, larger and noisier training set
        source_gap_pct = 0;
        sink_stall_pct = 0;
        test_training_set(330, 20);

        // Drain and let any stray result show up
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Ran %0d patterns (directed, set training, random), checked %0d results,",
                 patterns_sent, outcomes_checked);
        $display("%0d weight corrections, under three sender/receiver idle mixes.",
                 corrections_seen);
        if (error_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
